### design/i2cm_pkg.sv
// Package for the I2C master bit engine: command codes, sequence states,
// register defaults and the shared engine-state and result structs. No dependencies.
package i2cm_pkg;

	localparam int PHASE_W = 16;
	localparam int POLL_W  = 8;

	localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd10;
	localparam logic [POLL_W-1:0]  ACK_TIMEOUT_RST = 8'd200;

	// configuration register indexes
	typedef enum logic {
		REG_PHASE_TICKS = 1'b0,
		REG_ACK_TIMEOUT = 1'b1
	} i2cm_reg_t;

	typedef enum logic [2:0] {
		MODE_TICK  = 3'd0,
		MODE_START = 3'd1,
		MODE_STOP  = 3'd2,
		MODE_WRITE = 3'd3,
		MODE_READ  = 3'd4,
		MODE_WACK  = 3'd5,
		MODE_ACK   = 3'd6,
		MODE_NACK  = 3'd7
	} i2cm_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_ST_A    = 4'd1,
		ST_ST_B    = 4'd2,
		ST_SP_A    = 4'd3,
		ST_SP_B    = 4'd4,
		ST_WR_H    = 4'd5,
		ST_WR_L    = 4'd6,
		ST_WR_N    = 4'd7,
		ST_RD_H    = 4'd8,
		ST_RD_N    = 4'd9,
		ST_WA_A    = 4'd10,
		ST_WA_B    = 4'd11,
		ST_WA_POLL = 4'd12,
		ST_WA_END  = 4'd13,
		ST_AK_A    = 4'd14,
		ST_AK_B    = 4'd15
	} i2cm_state_t;

	typedef struct packed {
		i2cm_state_t        seq;
		logic [PHASE_W-1:0] phase;
		logic [2:0]         bit_cnt;
		logic [7:0]         shift;
		logic [POLL_W-1:0]  poll;
		logic               scl;
		logic               sda;
		logic               drv;
		logic [7:0]         rx;
		logic               fail;
	} i2cm_eng_t;

	// one result transaction
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_fail;
	} i2cm_res_t;

endpackage

### design/i2cm_ifs.sv
// Valid/ready channel interfaces for the I2C master bit engine.
// Depends on nothing; field widths follow the engine's item format.
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] tx_byte;
	logic       sda_in;

	modport source (output valid, output mode, output tx_byte, output sda_in, input ready);
	modport sink   (input valid, input mode, input tx_byte, input sda_in, output ready);
endinterface

interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_fail;

	modport source (output valid, output scl_level, output sda_level, output sda_drive,
		output busy_res, output done_res, output rx_byte, output ack_fail, input ready);
	modport sink   (input valid, input scl_level, input sda_level, input sda_drive,
		input busy_res, input done_res, input rx_byte, input ack_fail, output ready);
endinterface

### design/i2cm_core.sv
// Sequence engine: engine state registers and the per-tick next-state logic.
// Depends on i2cm_pkg.
module i2cm_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic [2:0]           mode,
	input  logic [7:0]           tx_byte,
	input  logic                 sda_in,
	input  logic [15:0]          phase_ticks,
	input  logic [7:0]           ack_timeout,
	output i2cm_pkg::i2cm_res_t  res
);
	import i2cm_pkg::*;

	i2cm_eng_t          st_q;
	i2cm_eng_t          st_d;
	logic               done_c;
	logic [PHASE_W-1:0] pt_eff;
	logic [PHASE_W-1:0] pc_dec;
	logic [POLL_W-1:0]  poll_inc;
	i2cm_mode_t         md;

	assign pt_eff   = (phase_ticks == '0) ? PHASE_W'(1) : phase_ticks;
	assign pc_dec   = (st_q.phase != '0) ? st_q.phase - PHASE_W'(1) : '0;
	assign poll_inc = st_q.poll + POLL_W'(1);
	assign md       = i2cm_mode_t'(mode);

	always_comb begin
		st_d   = st_q;
		done_c = 1'b0;
		if (st_q.seq == ST_IDLE) begin
			case (md)
				MODE_START: begin
					st_d.drv = 1'b1; st_d.sda = 1'b1; st_d.scl = 1'b1;
					st_d.phase = pt_eff; st_d.seq = ST_ST_A;
				end
				MODE_STOP: begin
					st_d.drv = 1'b1; st_d.scl = 1'b0; st_d.sda = 1'b0;
					st_d.phase = pt_eff; st_d.seq = ST_SP_A;
				end
				MODE_WRITE: begin
					st_d.drv = 1'b1; st_d.scl = 1'b0;
					st_d.shift = tx_byte; st_d.bit_cnt = '0; st_d.sda = tx_byte[7];
					st_d.phase = pt_eff; st_d.seq = ST_WR_H;
				end
				MODE_READ: begin
					st_d.drv = 1'b0; st_d.scl = 1'b0;
					st_d.shift = '0; st_d.bit_cnt = '0;
					st_d.phase = pt_eff; st_d.seq = ST_RD_H;
				end
				MODE_WACK: begin
					st_d.drv = 1'b0; st_d.scl = 1'b1;
					st_d.phase = pt_eff; st_d.seq = ST_WA_A;
				end
				MODE_ACK, MODE_NACK: begin
					st_d.scl = 1'b0; st_d.drv = 1'b1;
					st_d.sda = (md == MODE_NACK);
					st_d.phase = pt_eff; st_d.seq = ST_AK_A;
				end
				default: ;
			endcase
		end else if (st_q.seq == ST_WA_POLL) begin
			if (!sda_in) begin
				st_d.scl = 1'b0; st_d.phase = pt_eff; st_d.seq = ST_WA_END;
			end else begin
				st_d.poll = poll_inc;
				// timeout (a wrapped count also fails): run the stop sequence
				if (poll_inc >= ack_timeout || poll_inc == '0) begin
					st_d.fail = 1'b1;
					st_d.drv = 1'b1; st_d.scl = 1'b0; st_d.sda = 1'b0;
					st_d.phase = pt_eff; st_d.seq = ST_SP_A;
				end
			end
		end else begin
			st_d.phase = pc_dec;
			if (pc_dec == '0) begin
				case (st_q.seq)
					ST_ST_A: begin
						st_d.sda = 1'b0; st_d.phase = pt_eff; st_d.seq = ST_ST_B;
					end
					ST_ST_B: begin
						st_d.scl = 1'b0; st_d.seq = ST_IDLE; done_c = 1'b1;
					end
					ST_SP_A: begin
						st_d.scl = 1'b1; st_d.sda = 1'b1;
						st_d.phase = pt_eff; st_d.seq = ST_SP_B;
					end
					ST_SP_B: begin
						st_d.seq = ST_IDLE; done_c = 1'b1;
					end
					ST_WR_H: begin
						st_d.scl = 1'b1; st_d.phase = pt_eff; st_d.seq = ST_WR_L;
					end
					ST_WR_L: begin
						st_d.scl = 1'b0; st_d.phase = pt_eff; st_d.seq = ST_WR_N;
					end
					ST_WR_N: begin
						if (st_q.bit_cnt == 3'd7) begin
							st_d.bit_cnt = '0; st_d.seq = ST_IDLE; done_c = 1'b1;
						end else begin
							st_d.bit_cnt = st_q.bit_cnt + 3'd1;
							st_d.shift = {st_q.shift[6:0], 1'b0};
							st_d.sda = st_q.shift[6];
							st_d.phase = pt_eff; st_d.seq = ST_WR_H;
						end
					end
					ST_RD_H: begin
						st_d.scl = 1'b1;
						st_d.shift = {st_q.shift[6:0], sda_in};
						st_d.phase = pt_eff; st_d.seq = ST_RD_N;
					end
					ST_RD_N: begin
						if (st_q.bit_cnt == 3'd7) begin
							st_d.bit_cnt = '0; st_d.rx = st_q.shift;
							st_d.seq = ST_IDLE; done_c = 1'b1;
						end else begin
							st_d.bit_cnt = st_q.bit_cnt + 3'd1;
							st_d.scl = 1'b0; st_d.phase = pt_eff; st_d.seq = ST_RD_H;
						end
					end
					ST_WA_A: begin
						st_d.sda = 1'b1; st_d.phase = pt_eff; st_d.seq = ST_WA_B;
					end
					ST_WA_B: begin
						st_d.poll = '0; st_d.seq = ST_WA_POLL;
					end
					ST_WA_END: begin
						st_d.fail = 1'b0; st_d.seq = ST_IDLE; done_c = 1'b1;
					end
					ST_AK_A: begin
						st_d.scl = 1'b1; st_d.phase = pt_eff; st_d.seq = ST_AK_B;
					end
					ST_AK_B: begin
						st_d.scl = 1'b0; st_d.seq = ST_IDLE; done_c = 1'b1;
					end
					default: st_d.seq = ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// idle, counters clear, SCL/SDA high and driven
			st_q <= '{seq: ST_IDLE, phase: '0, bit_cnt: '0, shift: '0, poll: '0,
				scl: 1'b1, sda: 1'b1, drv: 1'b1, rx: '0, fail: 1'b0};
		end else if (acc) begin
			st_q <= st_d;
		end
	end

	always_comb begin
		res.scl_level = st_d.scl;
		res.sda_level = st_d.sda;
		res.sda_drive = st_d.drv;
		res.busy_res  = (st_d.seq != ST_IDLE);
		res.done_res  = done_c;
		res.rx_byte   = st_d.rx;
		res.ack_fail  = st_d.fail;
	end

	// a completed sequence always returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && done_c) |=> (st_q.seq == ST_IDLE))
		else $error("done without return to idle");

	// SDA is released for the whole ack poll
	a_poll_released: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.seq == ST_WA_POLL) |-> !st_q.drv)
		else $error("SDA driven during ack poll");

endmodule

### design/i2cm_out_buf.sv
// Two-entry result buffer (output register plus skid) for the bit engine.
// Depends on i2cm_pkg and i2cm_ifs.
module i2cm_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  i2cm_pkg::i2cm_res_t push_data,
	output logic                full,
	i2cm_out_if.source          out_ch
);
	import i2cm_pkg::*;

	i2cm_res_t out_q;
	i2cm_res_t skid_q;
	logic      out_vld_q;
	logic      skid_vld_q;
	logic      pop;

	assign full = skid_vld_q;
	assign pop  = out_vld_q && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= push;
			end else begin
				out_vld_q  <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
				if (push) skid_q <= push_data;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_ch.valid     = out_vld_q;
	assign out_ch.scl_level = out_q.scl_level;
	assign out_ch.sda_level = out_q.sda_level;
	assign out_ch.sda_drive = out_q.sda_drive;
	assign out_ch.busy_res  = out_q.busy_res;
	assign out_ch.done_res  = out_q.done_res;
	assign out_ch.rx_byte   = out_q.rx_byte;
	assign out_ch.ack_fail  = out_q.ack_fail;

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry without head entry");

	a_stall_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ch.ready && push) |=> skid_vld_q)
		else $error("result dropped while output stalled");

endmodule

### design/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: config registers, sequence core
// and result buffer. Depends on i2cm_pkg, i2cm_ifs, i2cm_core, i2cm_out_buf.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+----------------------------------------------
//  in_ch    | in  | valid/ready      | mode[2:0], tx_byte[7:0], sda_in
//  out_ch   | out | valid/ready      | scl_level, sda_level, sda_drive, busy_res,
//           |     |                  | done_res, rx_byte[7:0], ack_fail
//  cfg      | in  | cfg_we           | cfg_index (0 phase_ticks, 1 ack_timeout), cfg_wdata
//
// Each input transaction is one engine tick; one transaction per clock while in_ch.ready is
// high, and the result is registered into the output buffer on the accepting edge. The engine
// state updates on the same edge, so only the two-entry output buffer holds acceptance back.
// Reset (arst_n low) returns the engine to idle with SCL/SDA high and driven, and the
// config registers to phase_ticks 10, ack_timeout 200.
// A stalled output holds up to two results; in_ch.ready drops only when both are full.
module i2c_master_bit_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	i2cm_in_if.sink     in_ch,
	i2cm_out_if.source  out_ch
);
	import i2cm_pkg::*;

	logic [PHASE_W-1:0] phase_ticks_q;
	logic [POLL_W-1:0]  ack_timeout_q;
	logic               acc;
	logic               buf_full;
	i2cm_res_t          res;

	// config registers, to be written only while the engine is idle; the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (i2cm_reg_t'(cfg_index))
				REG_PHASE_TICKS: phase_ticks_q <= cfg_wdata;
				REG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata[POLL_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = !buf_full;
	assign acc         = in_ch.valid && !buf_full;

	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.mode        (in_ch.mode),
		.tx_byte     (in_ch.tx_byte),
		.sda_in      (in_ch.sda_in),
		.phase_ticks (phase_ticks_q),
		.ack_timeout (ack_timeout_q),
		.res         (res)
	);

	i2cm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_data (res),
		.full      (buf_full),
		.out_ch    (out_ch)
	);

endmodule

### verif/i2cm_pin_checker.sv
// Checker for the I2C master bit engine: watches the config port and both channels,
// predicts every result transaction and compares it. Depends on i2cm_pkg and i2cm_ifs.
module i2cm_pin_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	i2cm_in_if          in_ch,
	i2cm_out_if         out_ch,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import i2cm_pkg::*;

	logic [PHASE_W-1:0] phase_ticks;
	logic [POLL_W-1:0]  ack_timeout;
	i2cm_eng_t          eng;
	i2cm_res_t          expected_pins[$];
	i2cm_res_t          got;
	i2cm_res_t          want;

	function automatic void load_phase(input i2cm_state_t nxt);
		eng.phase = (phase_ticks == '0) ? 16'd1 : phase_ticks;
		eng.seq   = nxt;
	endfunction

	function automatic void begin_stop();
		eng.drv = 1'b1;
		eng.scl = 1'b0;
		eng.sda = 1'b0;
		load_phase(ST_SP_A);
	endfunction

	// one engine tick; returns the pins and flags seen after it
	function automatic i2cm_res_t next_pins(input i2cm_mode_t m, input logic [7:0] b,
		input logic s);
		logic      done;
		i2cm_res_t r;
		done = 1'b0;
		if (eng.seq == ST_IDLE) begin
			case (m)
				MODE_START: begin
					eng.drv = 1'b1;
					eng.sda = 1'b1;
					eng.scl = 1'b1;
					load_phase(ST_ST_A);
				end
				MODE_STOP: begin_stop();
				MODE_WRITE: begin
					eng.drv     = 1'b1;
					eng.scl     = 1'b0;
					eng.shift   = b;
					eng.bit_cnt = '0;
					eng.sda     = b[7];
					load_phase(ST_WR_H);
				end
				MODE_READ: begin
					eng.drv     = 1'b0;
					eng.scl     = 1'b0;
					eng.shift   = '0;
					eng.bit_cnt = '0;
					load_phase(ST_RD_H);
				end
				MODE_WACK: begin
					eng.drv = 1'b0;
					eng.scl = 1'b1;
					load_phase(ST_WA_A);
				end
				MODE_ACK, MODE_NACK: begin
					eng.scl = 1'b0;
					eng.drv = 1'b1;
					eng.sda = (m == MODE_NACK);
					load_phase(ST_AK_A);
				end
				default: ;
			endcase
		end else if (eng.seq == ST_WA_POLL) begin
			if (!s) begin
				eng.scl = 1'b0;
				load_phase(ST_WA_END);
			end else begin
				eng.poll = eng.poll + 8'd1;
				if (eng.poll >= ack_timeout || eng.poll == '0) begin
					eng.fail = 1'b1;
					begin_stop();
				end
			end
		end else begin
			if (eng.phase != '0)
				eng.phase = eng.phase - 16'd1;
			if (eng.phase == '0) begin
				case (eng.seq)
					ST_ST_A: begin
						eng.sda = 1'b0;
						load_phase(ST_ST_B);
					end
					ST_ST_B: begin
						eng.scl = 1'b0;
						eng.seq = ST_IDLE;
						done    = 1'b1;
					end
					ST_SP_A: begin
						eng.scl = 1'b1;
						eng.sda = 1'b1;
						load_phase(ST_SP_B);
					end
					ST_SP_B: begin
						eng.seq = ST_IDLE;
						done    = 1'b1;
					end
					ST_WR_H: begin
						eng.scl = 1'b1;
						load_phase(ST_WR_L);
					end
					ST_WR_L: begin
						eng.scl = 1'b0;
						load_phase(ST_WR_N);
					end
					ST_WR_N: begin
						if (eng.bit_cnt == 3'd7) begin
							eng.bit_cnt = '0;
							eng.seq     = ST_IDLE;
							done        = 1'b1;
						end else begin
							eng.bit_cnt = eng.bit_cnt + 3'd1;
							eng.shift   = {eng.shift[6:0], 1'b0};
							eng.sda     = eng.shift[7];
							load_phase(ST_WR_H);
						end
					end
					ST_RD_H: begin
						eng.scl   = 1'b1;
						eng.shift = {eng.shift[6:0], s};
						load_phase(ST_RD_N);
					end
					ST_RD_N: begin
						if (eng.bit_cnt == 3'd7) begin
							eng.bit_cnt = '0;
							eng.rx      = eng.shift;
							eng.seq     = ST_IDLE;
							done        = 1'b1;
						end else begin
							eng.bit_cnt = eng.bit_cnt + 3'd1;
							eng.scl     = 1'b0;
							load_phase(ST_RD_H);
						end
					end
					ST_WA_A: begin
						eng.sda = 1'b1;
						load_phase(ST_WA_B);
					end
					ST_WA_B: begin
						eng.poll = '0;
						eng.seq  = ST_WA_POLL;
					end
					ST_WA_END: begin
						eng.fail = 1'b0;
						eng.seq  = ST_IDLE;
						done     = 1'b1;
					end
					ST_AK_A: begin
						eng.scl = 1'b1;
						load_phase(ST_AK_B);
					end
					ST_AK_B: begin
						eng.scl = 1'b0;
						eng.seq = ST_IDLE;
						done    = 1'b1;
					end
					default: eng.seq = ST_IDLE;
				endcase
			end
		end
		r.scl_level = eng.scl;
		r.sda_level = eng.sda;
		r.sda_drive = eng.drv;
		r.busy_res  = (eng.seq != ST_IDLE);
		r.done_res  = done;
		r.rx_byte   = eng.rx;
		r.ack_fail  = eng.fail;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks = PHASE_TICKS_RST;
			ack_timeout = ACK_TIMEOUT_RST;
			eng.seq     = ST_IDLE;
			eng.phase   = '0;
			eng.bit_cnt = '0;
			eng.shift   = '0;
			eng.poll    = '0;
			eng.scl     = 1'b1;
			eng.sda     = 1'b1;
			eng.drv     = 1'b1;
			eng.rx      = '0;
			eng.fail    = 1'b0;
			expected_pins.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PHASE_TICKS)
					phase_ticks = cfg_wdata;
				else
					ack_timeout = cfg_wdata[POLL_W-1:0];
			end
			if (out_ch.valid && out_ch.ready) begin
				got.scl_level = out_ch.scl_level;
				got.sda_level = out_ch.sda_level;
				got.sda_drive = out_ch.sda_drive;
				got.busy_res  = out_ch.busy_res;
				got.done_res  = out_ch.done_res;
				got.rx_byte   = out_ch.rx_byte;
				got.ack_fail  = out_ch.ack_fail;
				if (expected_pins.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transaction, expected none, actual %h",
						$time, got);
				end else begin
					want = expected_pins.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected scl=%b sda=%b drv=%b busy=%b done=%b rx=%h fail=%b",
							$time, want.scl_level, want.sda_level, want.sda_drive,
							want.busy_res, want.done_res, want.rx_byte, want.ack_fail);
						$display("%0t:          actual scl=%b sda=%b drv=%b busy=%b done=%b rx=%h fail=%b",
							$time, got.scl_level, got.sda_level, got.sda_drive,
							got.busy_res, got.done_res, got.rx_byte, got.ack_fail);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_pins.push_back(next_pins(i2cm_mode_t'(in_ch.mode), in_ch.tx_byte,
					in_ch.sda_in));
			pending = expected_pins.size();
		end
	end

endmodule

### verif/tb_i2c_master_bit_engine.sv
// Testbench top for the I2C master bit engine: clock, reset, tick stimulus, config
// writes, output stalls, watchdog and verdict. Depends on i2cm_pkg, i2cm_ifs,
// i2c_master_bit_engine and i2cm_pin_checker.
module tb_i2c_master_bit_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import i2cm_pkg::*;

	// cycles with no transaction on either channel before the run is called hung
	localparam int QUIET_LIMIT = 2000;

	// output throttling: always ready, a random bit pattern, or ready on 3 of 4 random draws
	typedef enum logic [1:0] {
		RX_FREE    = 2'd0,
		RX_PATTERN = 2'd1,
		RX_RANDOM  = 2'd2
	} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_wdata;

	i2cm_in_if  in_ch();
	i2cm_out_if out_ch();

	int          errors;
	int          pending;
	int          in_count   = 0;
	int          out_count  = 0;
	logic        line_busy  = 1'b0;
	int          burst_left = 0;
	int          quiet      = 0;
	rx_style_t   rx_style   = RX_FREE;
	logic [31:0] rx_bits    = '1;
	logic [7:0]  rx_cycle   = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	i2c_master_bit_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	i2cm_pin_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.errors    (errors),
		.pending   (pending)
	);

	// Output-side stalls: whenever the 8-bit cycle counter wraps, pick a new style, so
	// free-running stretches alternate with patterned and random backpressure.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 8'd1;
		if (rx_cycle == '0) begin
			rx_style <= rx_style_t'($urandom_range(0, 2));
			rx_bits  <= $urandom;
		end
		case (rx_style)
			RX_FREE:    out_ch.ready <= 1'b1;
			RX_PATTERN: out_ch.ready <= rx_bits[rx_cycle[4:0]];
			default:    out_ch.ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Track result transactions so the stimulus knows when the engine is idle
	// and every expected result has drained.
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			out_count <= out_count + 1;
			line_busy <= out_ch.busy_res;
		end
	end

	// Watchdog: any transaction on either side resets the quiet count.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic logic sda_roll(input int pct_high);
		return ($urandom_range(0, 99) < pct_high);
	endfunction

	// One tick transaction. The sender runs in bursts; between bursts valid
	// drops for a random gap. Ready is sampled at the falling edge, where it
	// is settled, and the transaction completes at the next rising edge.
	task automatic send_item(input i2cm_mode_t m, input logic [7:0] b, input logic s);
		logic took;
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
		end
		in_ch.valid   <= 1'b1;
		in_ch.mode    <= m;
		in_ch.tx_byte <= b;
		in_ch.sda_in  <= s;
		do begin
			@(negedge clk);
			took = in_ch.ready;
			@(posedge clk);
		end while (!took);
		burst_left--;
		in_count++;
	endtask

	// Feed plain ticks until the engine reports idle, then let the result
	// pipeline drain. Results arrive through the registered output buffer,
	// so a stale busy only adds harmless idle ticks.
	task automatic run_to_idle(input int pct_high);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (out_count != in_count);
		while (line_busy)
			send_item(MODE_TICK, 8'($urandom), sda_roll(pct_high));
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (out_count != in_count);
		repeat (4) @(posedge clk);
	endtask

	task automatic command(input i2cm_mode_t m, input logic [7:0] b, input int pct_high);
		send_item(m, b, sda_roll(pct_high));
		run_to_idle(pct_high);
	endtask

	// Both registers, back to back with write enable held; only called idle.
	// The upper byte of the ack timeout write is junk the block must ignore.
	task automatic write_cfg(input logic [15:0] ticks, input logic [7:0] polls);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PHASE_TICKS;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_index <= REG_ACK_TIMEOUT;
		cfg_wdata <= {8'($urandom), polls};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly ticks with commands mixed in: commands landing while busy are
	// dropped, the rest start real sequences with random bytes and SDA.
	task automatic random_items(input int count, input int pct_high);
		i2cm_mode_t m;
		for (int i = 0; i < count; i++) begin
			m = ($urandom_range(0, 9) < 7) ? MODE_TICK : i2cm_mode_t'($urandom_range(1, 7));
			send_item(m, 8'($urandom), sda_roll(pct_high));
		end
		run_to_idle(0);
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_PHASE_TICKS;
		cfg_wdata     <= '0;
		in_ch.valid   <= 1'b0;
		in_ch.mode    <= MODE_TICK;
		in_ch.tx_byte <= '0;
		in_ch.sda_in  <= 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		send_item(MODE_TICK, 8'hFF, 1'b1);              // tick while idle does nothing
		command(MODE_START, 8'($urandom), 50);
		command(MODE_WACK, 8'($urandom), 0);             // acked at once
		command(MODE_ACK, 8'($urandom), 50);
		command(MODE_NACK, 8'($urandom), 50);
		command(MODE_STOP, 8'($urandom), 50);

		// short phases for the byte commands and a short ack timeout
		write_cfg(16'd2, 8'd5);
		command(MODE_WRITE, 8'hFF, 50);
		command(MODE_READ, 8'($urandom), 50);
		command(MODE_READ, 8'($urandom), 100);           // all-ones byte
		command(MODE_READ, 8'($urandom), 0);             // all-zeros byte
		send_item(MODE_WRITE, 8'hA5, 1'b0);
		command(MODE_START, 8'($urandom), 50);           // arrives busy, dropped
		command(MODE_WACK, 8'($urandom), 100);           // times out, stop follows
		command(MODE_WACK, 8'($urandom), 0);             // ack clears the fail flag

		// zero phase length is taken as one; zero timeout fails on first high poll
		write_cfg(16'h0000, 8'h00);
		command(MODE_WACK, 8'($urandom), 100);
		command(MODE_START, 8'($urandom), 50);
		command(MODE_WRITE, 8'($urandom), 50);
		command(MODE_READ, 8'($urandom), 50);
		random_items(50, 50);

		write_cfg(16'd1, 8'd1);
		random_items(90, 60);

		// short timeout with SDA mostly high: many failed acks
		write_cfg(16'd2, 8'd3);
		random_items(90, 85);

		// longest ack wait: poll count runs all the way to 255
		write_cfg(16'd1, 8'd255);
		command(MODE_WACK, 8'($urandom), 100);
		random_items(50, 40);

		write_cfg(16'd3, 8'd17);
		random_items(90, 70);

		// longest phase: the start stays in its first phase for these ticks
		write_cfg(16'hFFFF, 8'd200);
		send_item(MODE_START, 8'($urandom), 1'b1);
		repeat (20)
			send_item(MODE_TICK, 8'($urandom), 1'b1);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (out_count != in_count);
		repeat (4) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
design/i2cm_pkg.sv
design/i2cm_ifs.sv
design/i2cm_core.sv
design/i2cm_out_buf.sv
design/i2c_master_bit_engine.sv
verif/i2cm_pin_checker.sv
verif/tb_i2c_master_bit_engine.sv
